// File: sv/crc32c_pkg.sv
// ----------------------------------------------------------------------------
// crc32c_pkg
// Shared types, constants and GF(2) matrix helpers for the CRC-32C engine.
// ----------------------------------------------------------------------------
package crc32c_pkg;

    localparam int unsigned LANE_COUNT = 8;
    localparam int unsigned CRC_W      = 32;
    localparam logic [31:0] CRC_POLY   = 32'h82F63B78;
    localparam logic [31:0] ALL_ONES   = 32'hFFFFFFFF;
    localparam logic [3:0]  MAX_BYTES  = 4'd8;

    typedef logic [CRC_W-1:0]                        crc_t;
    typedef logic [7:0][CRC_W-1:0]                   lane_cols_t;  // one column per byte bit
    typedef logic [LANE_COUNT-1:0][7:0][CRC_W-1:0]   lane_tbl_t;
    typedef logic [CRC_W-1:0][CRC_W-1:0]             reg_cols_t;   // one column per crc bit
    typedef logic [LANE_COUNT:0][CRC_W-1:0][CRC_W-1:0] reg_tbl_t;
    typedef logic [LANE_COUNT-1:0][CRC_W-1:0]        lane_sum_t;

    // Control that travels with a word down the pipeline
    typedef struct packed {
        logic       valid;
        logic       start;
        logic       last;
        logic [3:0] nbytes;
        crc_t       seed;
    } stage_ctrl_t;

    // Advance the reflected register by a number of zero bits
    function automatic crc_t crc_advance(crc_t r, int unsigned nbits);
        crc_t acc;
        acc = r;
        for (int unsigned i = 0; i < nbits; i++) begin
            if (acc[0])
                acc = (acc >> 1) ^ CRC_POLY;
            else
                acc = acc >> 1;
        end
        return acc;
    endfunction

    // Lane j holds the byte that still has (8 - j) byte steps to go
    function automatic lane_tbl_t build_lane_tbl();
        lane_tbl_t tbl;
        for (int unsigned j = 0; j < LANE_COUNT; j++) begin
            for (int unsigned k = 0; k < 8; k++) begin
                tbl[j][k] = crc_advance(crc_t'(1) << k, 8 * (LANE_COUNT - j));
            end
        end
        return tbl;
    endfunction

    // Entry n advances the running register by n bytes
    function automatic reg_tbl_t build_reg_tbl();
        reg_tbl_t tbl;
        for (int unsigned n = 0; n <= LANE_COUNT; n++) begin
            for (int unsigned m = 0; m < CRC_W; m++) begin
                tbl[n][m] = crc_advance(crc_t'(1) << m, 8 * n);
            end
        end
        return tbl;
    endfunction

    localparam lane_tbl_t LANE_TBL = build_lane_tbl();
    localparam reg_tbl_t  REG_TBL  = build_reg_tbl();

    // Byte times matrix: XOR of the columns picked by set bits
    function automatic crc_t byte_mul(lane_cols_t cols, logic [7:0] b);
        crc_t acc;
        acc = '0;
        for (int unsigned k = 0; k < 8; k++) begin
            if (b[k])
                acc = acc ^ cols[k];
        end
        return acc;
    endfunction

    // Register times matrix
    function automatic crc_t reg_mul(reg_cols_t cols, crc_t v);
        crc_t acc;
        acc = '0;
        for (int unsigned m = 0; m < CRC_W; m++) begin
            if (v[m])
                acc = acc ^ cols[m];
        end
        return acc;
    endfunction

endpackage

// File: sv/crc32c_stream_if.sv
// ----------------------------------------------------------------------------
// crc32c_stream interfaces
// Valid/ready channels for message words and for finished CRC values.
// ----------------------------------------------------------------------------
interface crc32c_msg_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        start_req;
    logic        last;
    logic [31:0] seed;

    modport source (output valid, output data_word, output valid_bytes,
                    output start_req, output last, output seed, input ready);
    modport sink   (input valid, input data_word, input valid_bytes,
                    input start_req, input last, input seed, output ready);
endinterface

interface crc32c_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink   (input valid, input crc_value, output ready);
endinterface

// File: sv/crc32c_align.sv
// ----------------------------------------------------------------------------
// crc32c_align
// Clamps the byte count and pushes the valid bytes to the top of the word,
// so every lane sees a fixed distance to the end of the word.
// ----------------------------------------------------------------------------
module crc32c_align
    import crc32c_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        take,
    input  logic [63:0] data_word,
    input  logic [3:0]  valid_bytes,
    input  logic        start_req,
    input  logic        last,
    input  logic [31:0] seed,
    output stage_ctrl_t ctrl,
    output logic [63:0] aligned
);

    logic [3:0]  nbytes;
    logic [3:0]  pad_bytes;
    logic [6:0]  shamt;
    stage_ctrl_t ctrl_reg, ctrl_next;
    logic [63:0] aligned_reg, aligned_next;

    // Saturate the count and compute the left shift
    always_comb
    begin
        nbytes    = (valid_bytes > MAX_BYTES) ? MAX_BYTES : valid_bytes;
        pad_bytes = MAX_BYTES - nbytes;
        shamt     = {pad_bytes, 3'b000};
        aligned_next     = data_word << shamt;
        ctrl_next.valid  = take;
        ctrl_next.start  = start_req;
        ctrl_next.last   = last;
        ctrl_next.nbytes = nbytes;
        ctrl_next.seed   = seed;
    end

    // Hold control while the pipeline is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else if (advance)
            ctrl_reg <= ctrl_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            aligned_reg <= aligned_next;
    end

    assign ctrl    = ctrl_reg;
    assign aligned = aligned_reg;

endmodule

// File: sv/crc32c_lane.sv
// ----------------------------------------------------------------------------
// crc32c_lane
// One byte lane: multiplies its byte by the lane's constant GF(2) matrix,
// giving that byte's share of the CRC at the end of the word.
// ----------------------------------------------------------------------------
module crc32c_lane
    import crc32c_pkg::*;
(
    input  logic       clk,
    input  logic       advance,
    input  logic [2:0] lane_idx,
    input  logic [7:0] byte_in,
    output crc_t       contrib
);

    crc_t contrib_reg, contrib_next;

    // Fold the byte through the lane matrix
    always_comb
    begin
        contrib_next = byte_mul(LANE_TBL[lane_idx], byte_in);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            contrib_reg <= contrib_next;
    end

    assign contrib = contrib_reg;

endmodule

// File: sv/crc32c_merge.sv
// ----------------------------------------------------------------------------
// crc32c_merge
// Combines the lane shares with the advanced running register, keeps the
// running CRC and holds the finished value for the result channel.
// ----------------------------------------------------------------------------
module crc32c_merge
    import crc32c_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  stage_ctrl_t ctrl,
    input  lane_sum_t   lane_contrib,
    input  logic        res_ready,
    output logic        advance,
    output logic        res_valid,
    output crc_t        res_crc
);

    crc_t running_reg, running_next;
    logic out_valid_reg, out_valid_next;
    crc_t out_crc_reg, out_crc_next;
    crc_t base;
    crc_t data_share;
    crc_t updated;

    // Move forward whenever the output slot is free or being drained
    assign advance = !out_valid_reg || res_ready;

    // Merge lanes and fold in the running register
    always_comb
    begin
        data_share = '0;
        for (int unsigned j = 0; j < LANE_COUNT; j++) begin
            data_share = data_share ^ lane_contrib[j];
        end
        base    = ctrl.start ? ~ctrl.seed : running_reg;
        updated = reg_mul(REG_TBL[ctrl.nbytes], base) ^ data_share;
    end

    // Next running value and output slot
    always_comb
    begin
        running_next   = running_reg;
        out_valid_next = out_valid_reg;
        out_crc_next   = out_crc_reg;
        if (advance) begin
            out_valid_next = ctrl.valid && ctrl.last;
            out_crc_next   = ~updated;
            if (ctrl.valid)
                running_next = ctrl.last ? ALL_ONES : updated;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            running_reg   <= ALL_ONES;
            out_valid_reg <= 1'b0;
        end
        else begin
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_crc_reg <= out_crc_next;
    end

    assign res_valid = out_valid_reg;
    assign res_crc   = out_crc_reg;

endmodule

// File: sv/crc32c_stream_top.sv
// ----------------------------------------------------------------------------
// crc32c_stream_top
// Reflected CRC-32C over 64-bit message words, eight byte lanes per word.
// ----------------------------------------------------------------------------
//  Channel   Role     Payload
//  msg       sink     data_word, valid_bytes, start_req, last, seed
//  result    source   crc_value (one transfer per word marked last)
//
//  Takes one word per cycle while msg.ready is high; a last word passes the alignment,
//  lane and merge output registers before its result appears. Stages: byte alignment,
//  eight lane multipliers, merge with the running CRC. The running-CRC feedback closes in the merge stage.
//  A stalled result holds every stage; msg.ready falls only while it waits.
//  Reset clears the pipeline and sets the running CRC to all ones.
// ----------------------------------------------------------------------------
module crc32c_stream_top
    import crc32c_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    crc32c_msg_if.sink   msg,
    crc32c_res_if.source result
);

    logic        advance;
    stage_ctrl_t s1_ctrl;
    logic [63:0] s1_aligned;
    stage_ctrl_t s2_ctrl_reg, s2_ctrl_next;
    lane_sum_t   lane_contrib;

    assign msg.ready = advance;

    // Align valid bytes to the end of the word
    crc32c_align u_align (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .take        (msg.valid),
        .data_word   (msg.data_word),
        .valid_bytes (msg.valid_bytes),
        .start_req   (msg.start_req),
        .last        (msg.last),
        .seed        (msg.seed),
        .ctrl        (s1_ctrl),
        .aligned     (s1_aligned)
    );

    // Byte lanes work side by side
    for (genvar j = 0; j < LANE_COUNT; j++) begin : g_lane
        crc32c_lane u_lane (
            .clk      (clk),
            .advance  (advance),
            .lane_idx (3'(j)),
            .byte_in  (s1_aligned[8*j +: 8]),
            .contrib  (lane_contrib[j])
        );
    end

    // Carry control alongside the lane stage
    assign s2_ctrl_next = s1_ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_ctrl_reg <= '0;
        else if (advance)
            s2_ctrl_reg <= s2_ctrl_next;
    end

    // Merge lanes, update running CRC, hold result
    crc32c_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (s2_ctrl_reg),
        .lane_contrib (lane_contrib),
        .res_ready    (result.ready),
        .advance      (advance),
        .res_valid    (result.valid),
        .res_crc      (result.crc_value)
    );

endmodule

// File: tb/tb_crc32c_stream_top.sv
// ----------------------------------------------------------------------------
// tb_crc32c_stream_top
// Self-checking bench for the streaming CRC-32C engine. Message words are
// sent in bursts with random gaps while the result side stalls on its own
// pattern. A bit-serial CRC model in the scoreboard predicts each final CRC,
// and every result transfer is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_crc32c_stream_top;
    import crc32c_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TOTAL_WORDS    = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // Bit-serial CRC-32C model and queue of pending CRC values
    class crc_scoreboard;
        crc_t msg_crc;
        crc_t crc_q[$];
        int   errors;
        int   shown;

        function new();
            msg_crc = ALL_ONES;
            errors  = 0;
            shown   = 0;
        endfunction

        function void report(string text);
            if (shown < 50)
                $display("ERROR @%0t: %s", $realtime, text);
            shown++;
            errors++;
        endfunction

        // Fold one byte into the reflected register, LSB first
        function crc_t fold_octet(crc_t r, logic [7:0] b);
            crc_t acc;
            acc = r ^ {24'h0, b};
            for (int k = 0; k < 8; k++)
                acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
            return acc;
        endfunction

        function void note_word(logic [63:0] w, logic [3:0] n, logic s, logic l,
                                crc_t sd);
            crc_t acc;
            int   cnt;
            cnt = (n > MAX_BYTES) ? int'(MAX_BYTES) : int'(n);
            acc = s ? ~sd : msg_crc;
            for (int i = 0; i < cnt; i++)
                acc = fold_octet(acc, w[8*i +: 8]);
            if (l)
            begin
                crc_q.push_back(~acc);
                msg_crc = ALL_ONES;
            end
            else
            begin
                msg_crc = acc;
            end
        endfunction

        function void check_crc(crc_t got);
            crc_t want;
            if (crc_q.size() == 0)
            begin
                report($sformatf("crc %h with no message pending", got));
                return;
            end
            want = crc_q.pop_front();
            if (got !== want)
                report($sformatf("crc_value mismatch: got %h expected %h", got, want));
        endfunction

        function int pending();
            return crc_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    crc32c_msg_if msg_bus();
    crc32c_res_if crc_bus();

    crc32c_stream_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_bus),
        .result (crc_bus)
    );

    crc_scoreboard sb = new();

    bit hold_req;
    bit hold_taken;
    bit no_gaps;
    int burst_left;
    int words_sent;
    int idle_cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Record accepted words and check finished CRCs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (msg_bus.valid && msg_bus.ready)
                sb.note_word(msg_bus.data_word, msg_bus.valid_bytes, msg_bus.start_req,
                             msg_bus.last, msg_bus.seed);
            if (crc_bus.valid && crc_bus.ready)
                sb.check_crc(crc_bus.crc_value);
        end
    end

    // Watchdog: end the run when nothing transfers for too long
    always @(posedge clk)
    begin
        if ((msg_bus.valid && msg_bus.ready) || (crc_bus.valid && crc_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: stall pattern changes mode every stretch, long hold on request
    initial
    begin
        int  mode;
        int  mode_left;
        int  phase;
        bit  rdy;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        crc_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                crc_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                phase++;
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    2:       rdy = (phase % 3 == 0);
                    default: rdy = ($urandom_range(0, 9) != 0);
                endcase
                crc_bus.ready <= rdy;
            end
        end
    end

    // Offer one word and hold it until the transfer; idle between bursts
    task automatic put_word(logic [63:0] w, logic [3:0] n, logic s, logic l, crc_t sd);
        int gap;
        msg_bus.valid       <= 1'b1;
        msg_bus.data_word   <= w;
        msg_bus.valid_bytes <= n;
        msg_bus.start_req   <= s;
        msg_bus.last        <= l;
        msg_bus.seed        <= sd;
        do
            @(posedge clk);
        while (!msg_bus.ready);
        words_sent++;
        if (!no_gaps)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 40);
                msg_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // Stop sending and wait until every pending CRC has come back
    task automatic wait_crc_drain();
        msg_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic logic [3:0] pick_nbytes(bit is_last);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return 4'd0;
        if (r < 9)
            return 4'($urandom_range(9, 15));
        if (is_last || r < 30)
            return 4'($urandom_range(1, 8));
        return MAX_BYTES;
    endfunction

    function automatic logic [63:0] pick_data();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return '0;
        if (r < 6)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic crc_t pick_seed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return ALL_ONES;
        return $urandom;
    endfunction

    // One message: mostly well formed, some without start, restarted or unfinished
    task automatic send_message();
        int  len;
        int  kind;
        int  r;
        bit  s;
        bit  l;
        r = $urandom_range(0, 99);
        if (r < 75)
            len = $urandom_range(1, 4);
        else if (r < 95)
            len = $urandom_range(5, 12);
        else
            len = $urandom_range(13, 24);
        kind = $urandom_range(0, 99);
        for (int i = 0; i < len; i++)
        begin
            s = (i == 0 && (kind < 85 || kind >= 92)) ||
                (kind >= 92 && kind < 96 && i == len / 2);
            l = (i == len - 1) && (kind < 96);
            put_word(pick_data(), pick_nbytes(l), s, l, pick_seed());
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n               <= 1'b0;
        msg_bus.valid       <= 1'b0;
        msg_bus.data_word   <= '0;
        msg_bus.valid_bytes <= '0;
        msg_bus.start_req   <= 1'b0;
        msg_bus.last        <= 1'b0;
        msg_bus.seed        <= '0;
        hold_req    = 1'b0;
        no_gaps     = 1'b0;
        burst_left  = 0;
        words_sent  = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Start-less words right after reset run from the reset value
        put_word(64'h0123_4567_89AB_CDEF, 4'd8, 1'b0, 1'b0, 32'hDEAD_BEEF);
        put_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd3, 1'b0, 1'b1, 32'h0000_0000);
        // After a last word a start-less message acts as seeded with zero
        put_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 1'b1, 32'hFFFF_FFFF);
        // Single word with no bytes returns the seed
        put_word(64'hA5A5_A5A5_5A5A_5A5A, 4'd0, 1'b1, 1'b1, 32'h1234_5678);
        put_word(64'h0000_0000_0000_0000, 4'd8, 1'b1, 1'b1, 32'h0000_0000);
        put_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b1, 32'hFFFF_FFFF);
        // Byte counts above eight saturate
        put_word(64'h8000_0000_0000_0001, 4'd15, 1'b1, 1'b1, 32'h8000_0001);
        put_word(64'h7FFF_FFFF_FFFF_FFFE, 4'd9, 1'b1, 1'b1, 32'hFFFF_FFFE);
        // Standard check string split over two words
        put_word(64'h3837_3635_3433_3231, 4'd8, 1'b1, 1'b0, 32'h0000_0000);
        put_word(64'h0000_0000_0000_0039, 4'd1, 1'b0, 1'b1, 32'h0000_0000);
        // Empty middle word, then a restart inside the message
        put_word(64'h1122_3344_5566_7788, 4'd1, 1'b1, 1'b0, 32'hCAFE_F00D);
        put_word(64'hFFFF_0000_FFFF_0000, 4'd0, 1'b0, 1'b0, 32'h0BAD_0BAD);
        put_word(64'h0F0F_0F0F_F0F0_F0F0, 4'd12, 1'b1, 1'b0, 32'h5555_AAAA);
        put_word(64'hDEAD_BEEF_0BAD_F00D, 4'd5, 1'b0, 1'b1, 32'hAAAA_5555);
        // Byte counts one to seven on single-word messages
        for (int n = 1; n <= 7; n++)
            put_word({$urandom, $urandom}, 4'(n), 1'b1, 1'b1, $urandom);

        // Sender pause until all results are back
        wait_crc_drain();

        while (words_sent < TOTAL_WORDS)
        begin
            if (words_sent >= 800 && !hold_req)
            begin
                // Hold the result side while words keep coming, back to back
                hold_req = 1'b1;
                no_gaps  = 1'b1;
                while (words_sent < 900)
                    send_message();
                no_gaps = 1'b0;
            end
            else if (words_sent >= 1400 && words_sent < 1420)
            begin
                send_message();
                wait_crc_drain();
            end
            else
            begin
                send_message();
            end
        end

        wait_crc_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
